// File: sv/bbc_pkg.sv
// shared types, character codes and error codes of the bracket balance checker
package bbc_pkg;

    // error codes carried on the verdict
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNMATCHED = 3'd1;
    localparam logic [2:0] ERR_WRONG     = 3'd2;
    localparam logic [2:0] ERR_UNCLOSED  = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    // ascii characters of interest
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // bracket kinds as kept on the stack
    localparam int unsigned KIND_W = 2;
    localparam logic [KIND_W-1:0] BK_PAREN  = 2'd0;
    localparam logic [KIND_W-1:0] BK_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] BK_CURLY  = 2'd2;

    // stack commands from the checker, at most one of push and pop
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stack_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stack_flags;

    function automatic logic [KIND_W-1:0] bracket_kind(input logic [7:0] ch);
        logic [KIND_W-1:0] k;
        case (ch)
            CH_LPAREN, CH_RPAREN:   k = BK_PAREN;
            CH_LSQUARE, CH_RSQUARE: k = BK_SQUARE;
            default:                k = BK_CURLY;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] opener_ascii(input logic [KIND_W-1:0] k);
        logic [7:0] ch;
        case (k)
            BK_PAREN:  ch = CH_LPAREN;
            BK_SQUARE: ch = CH_LSQUARE;
            default:   ch = CH_LCURLY;
        endcase
        return ch;
    endfunction

endpackage

// File: sv/bbc_stack.sv
// opener stack: top-of-stack register in front of a memory with registered read
module bbc_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int POS_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bbc_pkg::t_stack_op           i_op,
    input  logic [bbc_pkg::KIND_W+2*POS_BITS-1:0] i_push_data,
    output logic [bbc_pkg::KIND_W+2*POS_BITS-1:0] o_top,
    output bbc_pkg::t_stack_flags        o_flags
);
    import bbc_pkg::*;

    localparam int ENT_W  = KIND_W + 2 * POS_BITS;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [ENT_W-1:0]  mem [STACK_DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ENT_W-1:0]  r_top, n_top;
    logic [ENT_W-1:0]  r_rdata;
    logic [ENT_W-1:0]  r_byp_data;
    logic              r_byp, n_byp;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CNT_W-1:0]  cnt_m1, ncnt_m2;
    logic [ENT_W-1:0]  below;

    // entry just under the top, forwarded when it was written last cycle
    assign below = r_byp ? r_byp_data : r_rdata;

    assign cnt_m1  = r_count - CNT_W'(1);
    assign waddr   = cnt_m1[ADDR_W-1:0];
    assign ncnt_m2 = n_count - CNT_W'(2);
    assign raddr   = ncnt_m2[ADDR_W-1:0];

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        we      = 1'b0;
        if (i_op.clear) begin
            n_count = '0;
        end else if (i_op.push) begin
            we      = (r_count != '0);
            n_top   = i_push_data;
            n_count = r_count + CNT_W'(1);
        end else if (i_op.pop) begin
            n_top   = below;
            n_count = cnt_m1;
        end
        n_byp = we && (waddr == raddr);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= r_top;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_byp_data <= r_top;
        if (!i_rst_n) begin
            r_count <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_byp   <= n_byp;
        end
    end

    assign o_top         = r_top;
    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count >= CNT_W'(STACK_DEPTH));

endmodule

// File: sv/bracket_balance_checker_core.sv
// top level of the bracket balance checker: position tracking, error latch, verdict register
//
// usage:
//   input channel  (i_valid, o_stall): one text byte per transaction, or a terminator
//     transaction with i_end_of_text high that asks for the verdict of the text so far
//   output channel (o_valid, i_stall): one verdict transaction per terminator, nothing
//     for ordinary bytes
// throughput: one input transaction per cycle while o_stall is low; the stack keeps its top entry
//   in a register and prefetches the entry below it from the stack memory every cycle,
//   so back-to-back pops and pushes never hold off the input
// output: the verdict is registered and appears on o_valid in the cycle after its terminator is accepted
// stall: while a verdict waits and i_stall is high, ordinary bytes are still taken;
//   only a further terminator is held off through o_stall
// reset: synchronous, active low; the stack empties, line and column go to 1, no error
//   is latched and the verdict register is empty; stack memory needs no clearing
// after each terminator the stack, position and error latch are cleared the same way for the next text
// the first error of a text is latched and later bytes are ignored until the terminator
module bracket_balance_checker_core #(
    parameter int STACK_DEPTH = 64,
    parameter int POS_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_error_kind,
    output logic [15:0] o_err_line,
    output logic [15:0] o_err_col,
    output logic [7:0]  o_bad_char,
    output logic [7:0]  o_open_char,
    output logic [15:0] o_open_line,
    output logic [15:0] o_open_col
);
    import bbc_pkg::*;

    localparam int ENT_W = KIND_W + 2 * POS_BITS;

    // positions go out as their low 16 bits
    function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[15:0];
    endfunction

    // text position, saturating
    logic [POS_BITS-1:0] r_line, n_line;
    logic [POS_BITS-1:0] r_col, n_col;

    // latched first error
    logic                r_err, n_err;
    logic [2:0]          r_sv_kind, n_sv_kind;
    logic [POS_BITS-1:0] r_sv_line, n_sv_line;
    logic [POS_BITS-1:0] r_sv_col, n_sv_col;
    logic [7:0]          r_sv_bad, n_sv_bad;
    logic [ENT_W-1:0]    r_sv_open, n_sv_open;

    // verdict register
    logic                r_out_valid;
    logic [2:0]          r_out_kind;
    logic [15:0]         r_out_line, r_out_col, r_out_oline, r_out_ocol;
    logic [7:0]          r_out_bad, r_out_ochar;

    t_stack_op           stk_op;
    t_stack_flags        stk_flags;
    logic [ENT_W-1:0]    stk_top;
    logic [ENT_W-1:0]    push_data;

    logic                in_acc, byte_acc, eot_acc;
    logic                is_open, is_closer;
    logic [KIND_W-1:0]   byte_kind, top_kind;
    logic [POS_BITS-1:0] top_line, top_col;
    logic [POS_BITS-1:0] line_inc, col_inc;

    // verdict fields as they leave on a terminator
    logic [2:0]          v_kind;
    logic [POS_BITS-1:0] v_line, v_col;
    logic [7:0]          v_bad;
    logic [ENT_W-1:0]    v_open;

    // only a terminator needs the verdict register, so only a terminator waits on it
    assign o_stall  = r_out_valid && i_stall && i_end_of_text;
    assign in_acc   = i_valid && !o_stall;
    assign byte_acc = in_acc && !i_end_of_text;
    assign eot_acc  = in_acc && i_end_of_text;

    assign is_open   = (i_text_byte == CH_LPAREN) || (i_text_byte == CH_LSQUARE)
                    || (i_text_byte == CH_LCURLY);
    assign is_closer = (i_text_byte == CH_RPAREN) || (i_text_byte == CH_RSQUARE)
                    || (i_text_byte == CH_RCURLY);
    assign byte_kind = bracket_kind(i_text_byte);

    assign top_kind = stk_top[ENT_W-1 -: KIND_W];
    assign top_line = stk_top[2*POS_BITS-1 -: POS_BITS];
    assign top_col  = stk_top[POS_BITS-1:0];

    assign line_inc = (&r_line) ? r_line : r_line + POS_BITS'(1);
    assign col_inc  = (&r_col) ? r_col : r_col + POS_BITS'(1);

    assign push_data = {byte_kind, r_line, r_col};

    // byte processing and error latch
    always_comb begin
        n_line    = r_line;
        n_col     = r_col;
        n_err     = r_err;
        n_sv_kind = r_sv_kind;
        n_sv_line = r_sv_line;
        n_sv_col  = r_sv_col;
        n_sv_bad  = r_sv_bad;
        n_sv_open = r_sv_open;
        stk_op    = '0;

        if (byte_acc && !r_err) begin
            if (i_text_byte == CH_NEWLINE) begin
                n_line = line_inc;
                n_col  = POS_BITS'(1);
            end else begin
                n_col = col_inc;
                if (is_open) begin
                    if (stk_flags.full) begin
                        n_err     = 1'b1;
                        n_sv_kind = ERR_OVERFLOW;
                        n_sv_line = r_line;
                        n_sv_col  = r_col;
                        n_sv_bad  = i_text_byte;
                    end else begin
                        stk_op.push = 1'b1;
                    end
                end else if (is_closer) begin
                    if (stk_flags.empty) begin
                        n_err     = 1'b1;
                        n_sv_kind = ERR_UNMATCHED;
                        n_sv_line = r_line;
                        n_sv_col  = r_col;
                        n_sv_bad  = i_text_byte;
                    end else begin
                        stk_op.pop = 1'b1;
                        if (top_kind != byte_kind) begin
                            n_err     = 1'b1;
                            n_sv_kind = ERR_WRONG;
                            n_sv_line = r_line;
                            n_sv_col  = r_col;
                            n_sv_bad  = i_text_byte;
                            n_sv_open = stk_top;
                        end
                    end
                end
            end
        end

        // terminator: clear for the next text
        if (eot_acc) begin
            stk_op.clear = 1'b1;
            n_line       = POS_BITS'(1);
            n_col        = POS_BITS'(1);
            n_err        = 1'b0;
        end
    end

    // verdict: latched error, else innermost unclosed opener, else balanced
    always_comb begin
        v_kind = ERR_NONE;
        v_line = '0;
        v_col  = '0;
        v_bad  = '0;
        v_open = '0;
        if (r_err) begin
            v_kind = r_sv_kind;
            v_line = r_sv_line;
            v_col  = r_sv_col;
            v_bad  = r_sv_bad;
            if (r_sv_kind == ERR_WRONG) begin
                v_open = r_sv_open;
            end
        end else if (!stk_flags.empty) begin
            v_kind = ERR_UNCLOSED;
            v_line = top_line;
            v_col  = top_col;
            v_bad  = opener_ascii(top_kind);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sv_kind <= n_sv_kind;
        r_sv_line <= n_sv_line;
        r_sv_col  <= n_sv_col;
        r_sv_bad  <= n_sv_bad;
        r_sv_open <= n_sv_open;
        if (eot_acc) begin
            r_out_kind  <= v_kind;
            r_out_line  <= pos16(v_line);
            r_out_col   <= pos16(v_col);
            r_out_bad   <= v_bad;
            r_out_ochar <= (v_kind == ERR_WRONG) ? opener_ascii(v_open[ENT_W-1 -: KIND_W])
                                                 : 8'd0;
            r_out_oline <= pos16(v_open[2*POS_BITS-1 -: POS_BITS]);
            r_out_ocol  <= pos16(v_open[POS_BITS-1:0]);
        end
        if (!i_rst_n) begin
            r_line      <= POS_BITS'(1);
            r_col       <= POS_BITS'(1);
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_line <= n_line;
            r_col  <= n_col;
            r_err  <= n_err;
            if (eot_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    bbc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .POS_BITS    (POS_BITS)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (stk_op),
        .i_push_data (push_data),
        .o_top       (stk_top),
        .o_flags     (stk_flags)
    );

    assign o_valid      = r_out_valid;
    assign o_error_kind = r_out_kind;
    assign o_err_line   = r_out_line;
    assign o_err_col    = r_out_col;
    assign o_bad_char   = r_out_bad;
    assign o_open_char  = r_out_ochar;
    assign o_open_line  = r_out_oline;
    assign o_open_col   = r_out_ocol;

    // a terminator always produces a verdict in the next cycle
    a_eot_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eot_acc |=> o_valid)
        else $error("no verdict after terminator");

    // a terminator leaves an empty stack and no latched error
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eot_acc |=> (stk_flags.empty && !r_err && r_line == POS_BITS'(1)
                     && r_col == POS_BITS'(1)))
        else $error("text state not cleared after terminator");

    // once an error is latched, ordinary bytes move neither position nor the stack flags
    a_latched_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && byte_acc) |=> ($stable(r_line) && $stable(r_col) && $stable(stk_flags)))
        else $error("state moved after latched error");

    // push never happens on a full stack, pop never on an empty one
    a_stack_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((stk_op.push && stk_flags.full) || (stk_op.pop && stk_flags.empty)))
        else $error("stack bound violated");

endmodule
